// ----- rtl/ptc_pkg.sv -----
package ptc_pkg;

  localparam int RESULT_CAP = 4;
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 8;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  // input command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ACTIVE   = 2'd1;
  localparam logic [1:0] CMD_INACTIVE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_ACTIVE   = 2'd0;
  localparam logic [1:0] REG_MAX_ACTIVE   = 2'd1;
  localparam logic [1:0] REG_MAX_INACTIVE = 2'd2;

  localparam logic [15:0] MIN_ACTIVE_RST   = 16'd10;
  localparam logic [15:0] MAX_ACTIVE_RST   = 16'd100;
  localparam logic [15:0] MAX_INACTIVE_RST = 16'd50;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SETUP    = 3'd1,
    PH_ACTIVE   = 3'd2,
    PH_WAIT     = 3'd3,
    PH_INACTIVE = 3'd4
  } ptc_phase_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_LINE_ON  = 2'd1,
    OP_LINE_OFF = 2'd2
  } ptc_op_t;

  typedef struct packed {
    ptc_op_t    op;
    logic [1:0] channel;
  } ptc_cmd_t;

  typedef struct packed {
    logic [15:0] min_active;
    logic [15:0] max_active;
    logic [15:0] max_inactive;
  } ptc_cfg_t;

  typedef struct packed {
    ptc_phase_t  phase;
    logic [15:0] left;
    logic [31:0] pulses;
  } ptc_ent_t;

  typedef struct packed {
    logic [1:0]  channel;
    ptc_phase_t  phase;
    logic [31:0] pulse_count;
    logic        train_done;
    logic        last;
  } ptc_res_t;

  localparam ptc_ent_t ENT_RESET = '{phase: PH_IDLE, left: 16'd0, pulses: 32'd0};

endpackage

// ----- rtl/pulse_train_counter_unit.sv -----
// Pulse counter with pulse width checks for CHANNELS channels. Line events (cmd 1 active,
// cmd 2 inactive) and ticks (cmd 0) are pushed into a short command queue; unknown codes
// and events for channels that do not exist are taken and dropped there. The back end
// keeps each channel's phase, timer and count in a state memory with one read and one
// write port and walks it: a line event runs the execute and flush states and gives one
// item, a tick reads each channel in turn on that port and gives one item per expired
// timer in ascending channel order, at most four. An item is started only when the
// result queue has room for four results, so a slow reader stalls the back end, and then
// the command queue fills and raises in_full. Registers: 0 min active ticks, 1 max active
// ticks, 2 max inactive ticks; a zero acts as one. cfg_ready is always high, and writes
// belong to idle periods only. Valid bits per channel make the state read as reset right
// after rst_n, so no clearing pass is needed.
module pulse_train_counter_unit #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_channel,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_channel,
  output logic [2:0]  out_phase,
  output logic [31:0] out_pulse_count,
  output logic        out_train_done,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ptc_pkg::ptc_cfg_t cfg_r;
  ptc_pkg::ptc_cmd_t cmd;
  ptc_pkg::ptc_res_t res;
  logic              cmd_pop, cmd_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_active   <= ptc_pkg::MIN_ACTIVE_RST;
      cfg_r.max_active   <= ptc_pkg::MAX_ACTIVE_RST;
      cfg_r.max_inactive <= ptc_pkg::MAX_INACTIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptc_pkg::REG_MIN_ACTIVE:   cfg_r.min_active   <= cfg_data;
        ptc_pkg::REG_MAX_ACTIVE:   cfg_r.max_active   <= cfg_data;
        ptc_pkg::REG_MAX_INACTIVE: cfg_r.max_inactive <= cfg_data;
        default: ;
      endcase
    end
  end

  ptc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_cmd     (in_cmd),
    .in_channel (in_channel),
    .in_full    (in_full),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd)
  );

  ptc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_channel     = res.channel;
  assign out_phase       = res.phase;
  assign out_pulse_count = res.pulse_count;
  assign out_train_done  = res.train_done;
  assign out_last        = res.last;

endmodule

// ----- rtl/ptc_fifo.sv -----
module ptc_fifo #(
  parameter int W     = 4,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ----- rtl/ptc_front.sv -----
module ptc_front #(
  parameter int CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [1:0]        in_cmd,
  input  logic [1:0]        in_channel,
  output logic              in_full,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output ptc_pkg::ptc_cmd_t cmd
);

  ptc_pkg::ptc_cmd_t                          cls;
  logic                                       keep;
  logic                                       ch_ok;
  logic [$bits(ptc_pkg::ptc_cmd_t)-1:0]       q_rdata;

  assign ch_ok = (32'(in_channel) < CHANNELS);

  // drop unknown codes and events for channels that do not exist
  always_comb begin
    cls.channel = in_channel;
    cls.op      = ptc_pkg::OP_TICK;
    keep        = 1'b0;
    unique case (in_cmd)
      ptc_pkg::CMD_TICK: begin
        keep = 1'b1;
      end
      ptc_pkg::CMD_ACTIVE: begin
        cls.op = ptc_pkg::OP_LINE_ON;
        keep   = ch_ok;
      end
      ptc_pkg::CMD_INACTIVE: begin
        cls.op = ptc_pkg::OP_LINE_OFF;
        keep   = ch_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  ptc_fifo #(
    .W     ($bits(ptc_pkg::ptc_cmd_t)),
    .DEPTH (ptc_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && keep),
    .wdata (cls),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (cmd_empty),
    .full  (in_full),
    .count ()
  );

  assign cmd = ptc_pkg::ptc_cmd_t'(q_rdata);

endmodule

// ----- rtl/ptc_back.sv -----
module ptc_back #(
  parameter int CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptc_pkg::ptc_cfg_t cfg,
  input  logic              cmd_empty,
  input  ptc_pkg::ptc_cmd_t cmd,
  output logic              cmd_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output ptc_pkg::ptc_res_t out_res
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OQ_CW = $clog2(ptc_pkg::OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FLUSH} state_t;

  state_t                      state_r, state_nxt;
  ptc_pkg::ptc_op_t            op_r, op_nxt;
  logic [CH_W-1:0]             ex_ch_r, ex_ch_nxt;
  logic [ptc_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic                        hold_v_r, hold_v_nxt;
  ptc_pkg::ptc_res_t           hold_r, hold_nxt;

  ptc_pkg::ptc_ent_t           ent_mem [CHANNELS];
  logic [CHANNELS-1:0]         vld_r;
  ptc_pkg::ptc_ent_t           rd_data_r;
  logic                        rd_vld_r;
  logic                        rd_en;
  logic [CH_W-1:0]             rd_addr;
  logic                        wr_en;

  ptc_pkg::ptc_ent_t           cur, upd;
  logic                        upd_wr, report, done;

  logic                        out_push, out_full;
  ptc_pkg::ptc_res_t           push_item;
  logic [OQ_CW-1:0]            out_count;
  logic [$bits(ptc_pkg::ptc_res_t)-1:0] oq_rdata;

  function automatic logic [15:0] nz(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] load_ticks(input ptc_pkg::ptc_phase_t ph,
                                             input ptc_pkg::ptc_cfg_t c);
    logic [15:0] v;
    v = 16'd0;
    case (ph)
      ptc_pkg::PH_SETUP:    v = nz(c.min_active);
      ptc_pkg::PH_ACTIVE:   v = nz(c.max_active);
      ptc_pkg::PH_INACTIVE: v = nz(c.max_inactive);
      default:              v = 16'd0;
    endcase
    return v;
  endfunction

  // entries never written read as the reset state
  assign cur = rd_vld_r ? rd_data_r : ptc_pkg::ENT_RESET;

  always_comb begin
    upd    = cur;
    upd_wr = 1'b0;
    report = 1'b0;
    done   = 1'b0;
    case (op_r)
      ptc_pkg::OP_TICK: begin
        if (cur.left != 16'd0) begin
          upd_wr   = 1'b1;
          upd.left = cur.left - 16'd1;
          if (cur.left == 16'd1) begin
            report = 1'b1;
            case (cur.phase)
              ptc_pkg::PH_SETUP:  upd.phase = ptc_pkg::PH_ACTIVE;
              ptc_pkg::PH_ACTIVE: upd.phase = ptc_pkg::PH_WAIT;
              ptc_pkg::PH_INACTIVE: begin
                upd.phase = ptc_pkg::PH_IDLE;
                done      = 1'b1;
              end
              default: upd.phase = ptc_pkg::PH_IDLE;
            endcase
            upd.left = load_ticks(upd.phase, cfg);
          end
        end
      end
      ptc_pkg::OP_LINE_ON: begin
        upd_wr = 1'b1;
        report = 1'b1;
        case (cur.phase) inside
          ptc_pkg::PH_INACTIVE: begin
            upd.phase = ptc_pkg::PH_SETUP;
            upd.left  = load_ticks(ptc_pkg::PH_SETUP, cfg);
          end
          ptc_pkg::PH_SETUP, ptc_pkg::PH_ACTIVE, ptc_pkg::PH_WAIT: begin
            upd = cur;
          end
          default: begin
            upd.pulses = 32'd0;
            upd.phase  = ptc_pkg::PH_SETUP;
            upd.left   = load_ticks(ptc_pkg::PH_SETUP, cfg);
          end
        endcase
      end
      ptc_pkg::OP_LINE_OFF: begin
        upd_wr = 1'b1;
        report = 1'b1;
        case (cur.phase)
          ptc_pkg::PH_ACTIVE: begin
            if (cur.pulses != 32'hFFFF_FFFF) begin
              upd.pulses = cur.pulses + 32'd1;
            end
            upd.phase = ptc_pkg::PH_INACTIVE;
            upd.left  = load_ticks(ptc_pkg::PH_INACTIVE, cfg);
          end
          ptc_pkg::PH_WAIT: begin
            upd.phase = ptc_pkg::PH_IDLE;
            upd.left  = 16'd0;
          end
          default: begin
            upd = cur;
          end
        endcase
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  // a result is held back one step so the last one of an item can be marked
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ex_ch_nxt  = ex_ch_r;
    n_nxt      = n_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    out_push   = 1'b0;
    push_item  = hold_r;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty && out_count <= OQ_CW'(ptc_pkg::OUTQ_DEPTH - ptc_pkg::RESULT_CAP)) begin
          cmd_pop    = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = (cmd.op == ptc_pkg::OP_TICK) ? '0 : CH_W'(cmd.channel);
          ex_ch_nxt  = rd_addr;
          op_nxt     = cmd.op;
          n_nxt      = '0;
          hold_v_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        wr_en = upd_wr;
        if (report && (op_r != ptc_pkg::OP_TICK ||
                       n_r < ptc_pkg::CNT_W'(ptc_pkg::RESULT_CAP))) begin
          if (hold_v_r) begin
            out_push       = 1'b1;
            push_item.last = 1'b0;
          end
          hold_nxt.channel     = 2'(ex_ch_r);
          hold_nxt.phase       = upd.phase;
          hold_nxt.pulse_count = upd.pulses;
          hold_nxt.train_done  = done;
          hold_nxt.last        = 1'b0;
          hold_v_nxt           = 1'b1;
          n_nxt                = n_r + ptc_pkg::CNT_W'(1);
        end
        if (op_r == ptc_pkg::OP_TICK && ex_ch_r != CH_W'(CHANNELS - 1)) begin
          rd_en     = 1'b1;
          rd_addr   = ex_ch_r + CH_W'(1);
          ex_ch_nxt = rd_addr;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (hold_v_r) begin
          out_push       = 1'b1;
          push_item.last = 1'b1;
        end
        hold_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ex_ch_r <= ex_ch_nxt;
    hold_r  <= hold_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hold_v_r <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      n_r      <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[ex_ch_r] <= upd;
    end
    if (rd_en) begin
      rd_data_r <= ent_mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[ex_ch_r] <= 1'b1;
    end
  end

  ptc_fifo #(
    .W     ($bits(ptc_pkg::ptc_res_t)),
    .DEPTH (ptc_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (push_item),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .full  (out_full),
    .count (out_count)
  );

  assign out_res = ptc_pkg::ptc_res_t'(oq_rdata);

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= ptc_pkg::CNT_W'(ptc_pkg::RESULT_CAP))
    else $error("result count beyond cap");

  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == S_EXEC)
    else $error("state write outside execution");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> state_r == S_IDLE && !hold_v_r)
    else $error("held result not flushed");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> rd_addr != ex_ch_r)
    else $error("read and write of the same channel in one cycle");
`endif

endmodule
